// ----- hdl/tbw_pkg.sv -----
// Shared types, codes and step functions for the two-button watch mode controller.
package tbw_pkg;

    localparam logic [3:0] KM_NORMAL     = 4'd0;
    localparam logic [3:0] KM_SET_HOUR   = 4'd1;
    localparam logic [3:0] KM_SET_MINUTE = 4'd2;
    localparam logic [3:0] KM_12_24      = 4'd3;
    localparam logic [3:0] KM_DATE       = 4'd4;
    localparam logic [3:0] KM_SET_MONTH  = 4'd5;
    localparam logic [3:0] KM_SET_DAY    = 4'd6;
    localparam logic [3:0] KM_YEAR       = 4'd7;
    localparam logic [3:0] KM_SET_YEAR   = 4'd8;
    localparam logic [3:0] KM_WEEKDAY    = 4'd9;
    localparam logic [3:0] KM_MESSAGE    = 4'd10;

    localparam logic [2:0] SM_TIME    = 3'd0;
    localparam logic [2:0] SM_12_24   = 3'd1;
    localparam logic [2:0] SM_DATE    = 3'd2;
    localparam logic [2:0] SM_YEAR    = 3'd3;
    localparam logic [2:0] SM_WEEKDAY = 3'd4;
    localparam logic [2:0] SM_MESSAGE = 3'd5;

    localparam logic [1:0] CFG_LONG_LIMIT    = 2'd0;
    localparam logic [1:0] CFG_SLEEP_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_MSG_LENGTH    = 2'd2;

    localparam logic [15:0] LONG_LIMIT_RESET    = 16'd1500;
    localparam logic [7:0]  SLEEP_TIMEOUT_RESET = 8'd5;
    localparam logic [7:0]  MSG_LENGTH_RESET    = 8'd19;
    localparam logic [7:0]  MSG_TAIL            = 8'd4;

    typedef struct packed {
        logic mode;
        logic sw1_level;
        logic sw2_level;
    } req_t;

    typedef struct packed {
        logic       hour_incr;
        logic       minute_incr;
        logic       month_incr;
        logic       day_incr;
        logic       year_incr;
        logic       toggle_12_24;
        logic [2:0] display_mode;
        logic       flash_left;
        logic       flash_right;
        logic [7:0] scroll_position;
        logic       sleep_request;
    } rsp_t;

    typedef struct packed {
        logic [1:0] rdy;
        logic [1:0] rpf;
        logic [1:0] held;
    } flags_t;

    typedef struct packed {
        logic [3:0]  key_mode;
        flags_t      flags;
        logic [1:0]  flash;
        logic [15:0] idle;
    } kb_t;

    typedef struct packed {
        kb_t  kb;
        logic cmd;
    } set_t;

    function automatic flags_t ready_check(flags_t f, logic [1:0] p);
        flags_t r;
        r = f;
        for (int b = 0; b < 2; b++)
        begin
            if (!r.rdy[b] && !p[b])
            begin
                r.rdy[b]  = 1'b1;
                r.held[b] = 1'b0;
            end
            else if (r.rdy[b] && p[b])
            begin
                r.rpf[b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic kb_t enter_mode(kb_t k, logic [3:0] nxt);
        kb_t r;
        r          = k;
        r.idle     = '0;
        r.flags    = '0;
        r.flash    = '0;
        r.key_mode = nxt;
        return r;
    endfunction

    function automatic set_t setting_mode(kb_t k, logic side, logic [3:0] nxt, logic [1:0] p);
        set_t r;
        r.kb  = k;
        r.cmd = 1'b0;
        r.kb.flash[side] = ~r.kb.flash[side];
        r.kb.flags = ready_check(r.kb.flags, p);
        if (r.kb.flags.rpf[0] && (r.kb.flags.held[0] || !p[0]) && !p[1])
        begin
            r.kb = enter_mode(r.kb, nxt);
        end
        else if (r.kb.flags.rpf[1] && p[1] && !p[0])
        begin
            if (r.kb.flags.held[1] && r.kb.flash[side])
            begin
                r.cmd = 1'b1;
            end
            else if (r.kb.flags.rdy[1])
            begin
                r.cmd = 1'b1;
                r.kb.flags.rdy[1] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic kb_t display_select(kb_t k, logic [3:0] on_long, logic [3:0] on_short,
                                           logic [1:0] p);
        kb_t r;
        r = k;
        r.flags = ready_check(r.flags, p);
        if (r.flags.rpf[0] && !p[1])
        begin
            if (r.flags.held[0])
            begin
                r = enter_mode(r, on_long);
            end
            else if (!p[0])
            begin
                r = enter_mode(r, on_short);
            end
        end
        return r;
    endfunction

endpackage

// ----- hdl/two_button_watch_mode_controller.sv -----
// Top level of the two-button watch mode controller: button sampling, key modes and scroll.
//
// Takes one request per clock cycle. Each request is processed in a single pass of
// combinational logic from the state registers and the request payload into the result
// register, so its result appears in the cycle after acceptance and stays until taken. The
// only thing that holds off requests is a full result register whose consumer stalls.
// Configuration writes take effect at the edge they are made and must fall while idle.
module two_button_watch_mode_controller
    import tbw_pkg::*;
#(
    parameter int SCROLL_DIVIDER = 4,
    parameter int WINDOW_BITS    = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SDM_W = (SCROLL_DIVIDER > 1) ? $clog2(SCROLL_DIVIDER) : 1;
    localparam logic [SDM_W-1:0] SDM_LAST = SDM_W'(SCROLL_DIVIDER - 1);

    logic [15:0] limit_reg;
    logic [7:0]  timeout_reg;
    logic [7:0]  msg_len_reg;

    kb_t                    kb_reg, kb_next;
    logic [2:0]             shown_reg, shown_next;
    logic [WINDOW_BITS-1:0] win_reg  [2];
    logic [WINDOW_BITS-1:0] win_next [2];
    logic [15:0]            hold_reg  [2];
    logic [15:0]            hold_next [2];
    logic [1:0]             pressed_reg, pressed_next;
    logic [7:0]             sdc_reg, sdc_next;
    logic [SDM_W-1:0]       sdm_reg, sdm_next;
    logic [7:0]             sp_reg, sp_next;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg, rsp_next;

    logic        accept;
    logic [1:0]  lvl;
    logic [11:0] sleep_thr;
    logic        sleep;
    set_t        set_res;
    logic [5:0]  cmd;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign lvl       = {req.sw2_level, req.sw1_level};

    // idle / 10 > timeout  <=>  idle > 10 * timeout + 9
    assign sleep_thr = {1'b0, timeout_reg, 3'b000} + {3'b000, timeout_reg, 1'b0} + 12'd9;

    always_comb
    begin
        kb_next      = kb_reg;
        shown_next   = shown_reg;
        win_next     = win_reg;
        hold_next    = hold_reg;
        pressed_next = pressed_reg;
        sdc_next     = sdc_reg;
        sdm_next     = sdm_reg;
        sp_next      = sp_reg;
        sleep        = 1'b0;
        cmd          = '0;
        set_res      = '0;

        if (req.mode)
        begin
            if (kb_next.idle > {4'b0000, sleep_thr})
            begin
                sleep   = 1'b1;
                kb_next = enter_mode(kb_next, KM_NORMAL);
            end

            unique case (kb_next.key_mode)
                KM_SET_HOUR:
                begin
                    set_res = setting_mode(kb_next, 1'b0, KM_SET_MINUTE, pressed_reg);
                    kb_next = set_res.kb;
                    cmd[5]  = set_res.cmd;
                end
                KM_SET_MINUTE:
                begin
                    set_res = setting_mode(kb_next, 1'b1, KM_12_24, pressed_reg);
                    kb_next = set_res.kb;
                    cmd[4]  = set_res.cmd;
                end
                KM_SET_MONTH:
                begin
                    set_res = setting_mode(kb_next, 1'b0, KM_SET_DAY, pressed_reg);
                    kb_next = set_res.kb;
                    cmd[3]  = set_res.cmd;
                end
                KM_SET_DAY:
                begin
                    set_res = setting_mode(kb_next, 1'b1, KM_DATE, pressed_reg);
                    kb_next = set_res.kb;
                    cmd[2]  = set_res.cmd;
                end
                KM_SET_YEAR:
                begin
                    set_res = setting_mode(kb_next, 1'b1, KM_YEAR, pressed_reg);
                    kb_next = set_res.kb;
                    cmd[1]  = set_res.cmd;
                end
                KM_12_24:
                begin
                    shown_next    = SM_12_24;
                    kb_next.flags = ready_check(kb_next.flags, pressed_reg);
                    if (kb_next.flags.rpf[0] && (kb_next.flags.held[0] || !pressed_reg[0])
                        && !pressed_reg[1])
                    begin
                        kb_next = enter_mode(kb_next, KM_NORMAL);
                    end
                    if (kb_next.flags.rdy[1] && pressed_reg[1] && !pressed_reg[0])
                    begin
                        cmd[0] = 1'b1;
                        kb_next.flags.rdy[1] = 1'b0;
                    end
                end
                KM_DATE:
                begin
                    shown_next = SM_DATE;
                    kb_next    = display_select(kb_next, KM_SET_MONTH, KM_YEAR, pressed_reg);
                end
                KM_YEAR:
                begin
                    shown_next = SM_YEAR;
                    kb_next    = display_select(kb_next, KM_SET_YEAR, KM_WEEKDAY, pressed_reg);
                end
                KM_WEEKDAY, KM_MESSAGE:
                begin
                    shown_next = (kb_next.key_mode == KM_WEEKDAY) ? SM_WEEKDAY : SM_MESSAGE;
                    kb_next.flags = ready_check(kb_next.flags, pressed_reg);
                    if (kb_next.flags.rpf[0] && !pressed_reg[0] && !pressed_reg[1])
                    begin
                        kb_next = enter_mode(kb_next, KM_NORMAL);
                    end
                end
                default:
                begin
                    shown_next    = SM_TIME;
                    kb_next.flags = ready_check(kb_next.flags, pressed_reg);
                    if (kb_next.flags.rpf[0] && !pressed_reg[1])
                    begin
                        if (kb_next.flags.held[0])
                        begin
                            kb_next = enter_mode(kb_next, KM_SET_HOUR);
                        end
                        else if (!pressed_reg[0])
                        begin
                            kb_next = enter_mode(kb_next, KM_DATE);
                        end
                    end
                    else if (kb_next.flags.rpf[1] && kb_next.flags.held[1]
                             && kb_next.flags.rpf[0] && kb_next.flags.held[0])
                    begin
                        sdc_next = '0;
                        sdm_next = '0;
                        sp_next  = '0;
                        kb_next  = enter_mode(kb_next, KM_MESSAGE);
                    end
                end
            endcase

            if (shown_next == SM_MESSAGE)
            begin
                sdc_next = sdc_next + 8'd1;
                if (sdm_next == '0)
                begin
                    if ({1'b0, sp_next} > ({1'b0, msg_len_reg} + {1'b0, MSG_TAIL}))
                    begin
                        kb_next = enter_mode(kb_next, KM_NORMAL);
                    end
                    else
                    begin
                        kb_next.idle = '0;
                    end
                    sp_next = sp_next + 8'd1;
                end
                // restart the phase at its last value, and whenever the delay count wraps
                if (sdc_next == '0 || sdm_next == SDM_LAST)
                begin
                    sdm_next = '0;
                end
                else
                begin
                    sdm_next = sdm_next + SDM_W'(1);
                end
            end

            if (pressed_reg[0] || pressed_reg[1])
            begin
                kb_next.idle = '0;
            end
            else
            begin
                kb_next.idle = kb_next.idle + 16'd1;
            end
        end
        else
        begin
            for (int b = 0; b < 2; b++)
            begin
                pressed_next[b] = (win_reg[b] == '0);
                if (pressed_next[b])
                begin
                    hold_next[b] = hold_reg[b] + 16'd1;
                    if (hold_reg[b] == limit_reg)
                    begin
                        kb_next.flags.held[b] = 1'b1;
                    end
                end
                else
                begin
                    hold_next[b] = '0;
                end
                win_next[b] = {win_reg[b][WINDOW_BITS-2:0], lvl[b]};
            end
        end

        rsp_next.hour_incr       = cmd[5];
        rsp_next.minute_incr     = cmd[4];
        rsp_next.month_incr      = cmd[3];
        rsp_next.day_incr        = cmd[2];
        rsp_next.year_incr       = cmd[1];
        rsp_next.toggle_12_24    = cmd[0];
        rsp_next.display_mode    = shown_next;
        rsp_next.flash_left      = kb_next.flash[0];
        rsp_next.flash_right     = kb_next.flash[1];
        rsp_next.scroll_position = sp_next;
        rsp_next.sleep_request   = sleep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LONG_LIMIT_RESET;
            timeout_reg <= SLEEP_TIMEOUT_RESET;
            msg_len_reg <= MSG_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LONG_LIMIT:    limit_reg   <= cfg_data;
                CFG_SLEEP_TIMEOUT: timeout_reg <= cfg_data[7:0];
                CFG_MSG_LENGTH:    msg_len_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kb_reg      <= '0;
            shown_reg   <= SM_TIME;
            win_reg     <= '{default: '0};
            hold_reg    <= '{default: '0};
            pressed_reg <= '0;
            sdc_reg     <= '0;
            sdm_reg     <= '0;
            sp_reg      <= '0;
        end
        else if (accept)
        begin
            kb_reg      <= kb_next;
            shown_reg   <= shown_next;
            win_reg     <= win_next;
            hold_reg    <= hold_next;
            pressed_reg <= pressed_next;
            sdc_reg     <= sdc_next;
            sdm_reg     <= sdm_next;
            sp_reg      <= sp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ----- hdl/tbw_checker.sv -----
// Port-level checks for the two-button watch mode controller, bound to its top level.
module tbw_checker
    import tbw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input rsp_t        rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("request stalled with empty result register");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot0({rsp.hour_incr, rsp.minute_incr, rsp.month_incr,
                                rsp.day_incr, rsp.year_incr, rsp.toggle_12_24}))
        else $error("more than one command in a result");

    a_sleep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.sleep_request |-> !(rsp.hour_incr || rsp.minute_incr
            || rsp.month_incr || rsp.day_incr || rsp.year_incr || rsp.toggle_12_24))
        else $error("command issued alongside sleep");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.display_mode <= SM_MESSAGE)
        else $error("display mode out of range");

endmodule

bind two_button_watch_mode_controller tbw_checker u_tbw_checker (.*);
